// ===== rtl/ihex_pkg.sv =====
// Shared types, constants and helpers for the Intel HEX record decoder.
// Depends on nothing; used by ihex_core, ihex_out_reg and intel_hex_record_decoder.
`timescale 1ns / 1ps

package ihex_pkg;

  localparam int ADDR_WIDTH = 32;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  localparam logic [2:0] KIND_WRITE  = 3'd0;
  localparam logic [2:0] KIND_GOOD   = 3'd1;
  localparam logic [2:0] KIND_CKSERR = 3'd2;
  localparam logic [2:0] KIND_EOF    = 3'd3;
  localparam logic [2:0] KIND_FMTERR = 3'd4;

  localparam logic [7:0] REC_DATA    = 8'h00;
  localparam logic [7:0] REC_EOF     = 8'h01;
  localparam logic [7:0] REC_SEGMENT = 8'h02;
  localparam logic [7:0] REC_LINEAR  = 8'h04;

  typedef struct packed {
    logic        valid;
    logic [2:0]  kind;
    logic [31:0] address;
    logic [7:0]  data;
  } res_t;

  // {ok, nibble}; ok is low for anything but 0-9, A-F, a-f
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

// ===== rtl/intel_hex_record_decoder.sv =====
// Intel HEX record decoder, top level: input register, parser, output register.
// A character is held in the input register, parsed combinationally, and its result is captured in the output register.
// Throughput: one character per cycle, set by the single-pass parser update, unless a result waits on result_stall.
// Reset (rst, synchronous): clears parser state, base address and the valid bits of both registers.
// Depends on ihex_pkg, ihex_in_reg, ihex_core, ihex_out_reg.
`timescale 1ns / 1ps

module intel_hex_record_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_stall,
  input  logic [7:0]  char_in,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  kind,
  output logic [31:0] address,
  output logic [7:0]  data
);

  logic           held_valid;
  logic [7:0]     held_char;
  logic           take;
  logic           out_can_take;
  ihex_pkg::res_t res;

  ihex_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_in    (char_in),
    .take       (take),
    .held_valid (held_valid),
    .held_char  (held_char)
  );

  ihex_core u_core (
    .clk          (clk),
    .rst          (rst),
    .held_valid   (held_valid),
    .held_char    (held_char),
    .out_can_take (out_can_take),
    .take         (take),
    .res          (res)
  );

  ihex_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .res          (res),
    .out_can_take (out_can_take),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .address      (address),
    .data         (data)
  );

endmodule

// ===== rtl/ihex_in_reg.sv =====
// Input register for the character stream.
// Depends on nothing; instantiated by intel_hex_record_decoder.
`timescale 1ns / 1ps

module ihex_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  logic [7:0] char_in,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_char
);

  assign char_stall = held_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!char_stall) begin
      held_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!char_stall && char_valid) begin
      held_char <= char_in;
    end
  end

endmodule

// ===== rtl/ihex_core.sv =====
// Record parser: decoder state and single-pass next-state logic per character.
// Depends on ihex_pkg.
`timescale 1ns / 1ps

module ihex_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              held_valid,
  input  logic [7:0]        held_char,
  input  logic              out_can_take,
  output logic              take,
  output ihex_pkg::res_t    res
);

  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_SKIP = 3'd1,
    PH_LEN  = 3'd2,
    PH_OFS  = 3'd3,
    PH_TYPE = 3'd4,
    PH_DATA = 3'd5,
    PH_CKS  = 3'd6,
    PH_TAIL = 3'd7
  } phase_t;

  localparam int AW = ihex_pkg::ADDR_WIDTH;

  phase_t          phase, phase_next;
  logic            nibble_pending, nibble_pending_next;
  logic [3:0]      high_nibble, high_nibble_next;
  logic [7:0]      byte_index, byte_index_next;
  logic [7:0]      record_length, record_length_next;
  logic [15:0]     record_offset, record_offset_next;
  logic [7:0]      record_type, record_type_next;
  logic [15:0]     extension_value, extension_value_next;
  logic [AW-1:0]   base_address, base_address_next;
  logic [AW-1:0]   write_address, write_address_next;
  logic [7:0]      running_sum, running_sum_next;
  logic            halted, halted_next;

  logic [4:0]      hx;
  logic [7:0]      b;
  logic [7:0]      idx_inc;
  logic            fire;
  ihex_pkg::res_t  r;

  assign hx      = ihex_pkg::hex_decode(held_char);
  assign b       = {high_nibble, hx[3:0]};
  assign idx_inc = byte_index + 8'd1;

  always_comb begin
    phase_next           = phase;
    nibble_pending_next  = nibble_pending;
    high_nibble_next     = high_nibble;
    byte_index_next      = byte_index;
    record_length_next   = record_length;
    record_offset_next   = record_offset;
    record_type_next     = record_type;
    extension_value_next = extension_value;
    base_address_next    = base_address;
    write_address_next   = write_address;
    running_sum_next     = running_sum;
    halted_next          = halted;
    r                    = '0;

    if (!halted) begin
      unique case (phase)
        PH_WAIT: begin
          if (held_char == ihex_pkg::CHAR_COLON) begin
            phase_next          = PH_LEN;
            nibble_pending_next = 1'b0;
            high_nibble_next    = 4'd0;
            byte_index_next     = 8'd0;
            record_length_next  = 8'd0;
            record_offset_next  = 16'd0;
            record_type_next    = 8'd0;
            running_sum_next    = 8'd0;
          end else if (held_char != ihex_pkg::CHAR_LF) begin
            phase_next = PH_SKIP;
          end
        end
        PH_SKIP, PH_TAIL: begin
          if (held_char == ihex_pkg::CHAR_LF) begin
            phase_next = PH_WAIT;
          end
        end
        default: begin
          if (!hx[4]) begin
            halted_next = 1'b1;
            r.valid     = 1'b1;
            r.kind      = ihex_pkg::KIND_FMTERR;
          end else if (!nibble_pending) begin
            high_nibble_next    = hx[3:0];
            nibble_pending_next = 1'b1;
          end else begin
            nibble_pending_next = 1'b0;
            running_sum_next    = running_sum + b;
            unique case (phase)
              PH_LEN: begin
                record_length_next = b;
                byte_index_next    = 8'd0;
                phase_next         = PH_OFS;
              end
              PH_OFS: begin
                record_offset_next = {record_offset[7:0], b};
                byte_index_next    = idx_inc;
                if (idx_inc >= 8'd2) begin
                  byte_index_next = 8'd0;
                  phase_next      = PH_TYPE;
                end
              end
              PH_TYPE: begin
                record_type_next     = b;
                write_address_next   = base_address + AW'(record_offset);
                extension_value_next = 16'd0;
                byte_index_next      = 8'd0;
                phase_next           = (record_length != 8'd0) ? PH_DATA : PH_CKS;
              end
              PH_DATA: begin
                if (record_type == ihex_pkg::REC_DATA) begin
                  r.valid            = 1'b1;
                  r.kind             = ihex_pkg::KIND_WRITE;
                  r.address          = 32'(write_address);
                  r.data             = b;
                  write_address_next = write_address + AW'(1);
                end else begin
                  extension_value_next = {extension_value[7:0], b};
                end
                byte_index_next = idx_inc;
                if (idx_inc >= record_length) begin
                  phase_next = PH_CKS;
                end
              end
              default: begin
                phase_next = PH_TAIL;
                r.valid    = 1'b1;
                if (running_sum_next != 8'd0) begin
                  halted_next = 1'b1;
                  r.kind      = ihex_pkg::KIND_CKSERR;
                end else if (record_type == ihex_pkg::REC_EOF) begin
                  halted_next = 1'b1;
                  r.kind      = ihex_pkg::KIND_EOF;
                end else begin
                  r.kind = ihex_pkg::KIND_GOOD;
                  if (record_type == ihex_pkg::REC_SEGMENT) begin
                    base_address_next = AW'({extension_value, 4'd0});
                  end else if (record_type == ihex_pkg::REC_LINEAR) begin
                    base_address_next = AW'({extension_value, 16'd0});
                  end
                end
              end
            endcase
          end
        end
      endcase
    end
  end

  assign fire = held_valid && (!r.valid || out_can_take);
  assign take = fire;

  always_comb begin
    res       = r;
    res.valid = r.valid && fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_WAIT;
      nibble_pending  <= 1'b0;
      high_nibble     <= 4'd0;
      byte_index      <= 8'd0;
      record_length   <= 8'd0;
      record_offset   <= 16'd0;
      record_type     <= 8'd0;
      extension_value <= 16'd0;
      base_address    <= '0;
      write_address   <= '0;
      running_sum     <= 8'd0;
      halted          <= 1'b0;
    end else if (fire) begin
      phase           <= phase_next;
      nibble_pending  <= nibble_pending_next;
      high_nibble     <= high_nibble_next;
      byte_index      <= byte_index_next;
      record_length   <= record_length_next;
      record_offset   <= record_offset_next;
      record_type     <= record_type_next;
      extension_value <= extension_value_next;
      base_address    <= base_address_next;
      write_address   <= write_address_next;
      running_sum     <= running_sum_next;
      halted          <= halted_next;
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted) else $error("halted cleared without reset");

  a_write_in_data: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.kind == ihex_pkg::KIND_WRITE |-> phase == PH_DATA)
    else $error("data write outside data phase");

  a_fmterr_halts: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.kind == ihex_pkg::KIND_FMTERR |=> halted)
    else $error("format error did not halt");

  a_no_result_halted: assert property (@(posedge clk) disable iff (rst)
    halted |-> !res.valid) else $error("result while halted");

endmodule

// ===== rtl/ihex_out_reg.sv =====
// Output register holding one result word until the consumer takes it.
// Depends on ihex_pkg.
`timescale 1ns / 1ps

module ihex_out_reg (
  input  logic            clk,
  input  logic            rst,
  input  ihex_pkg::res_t  res,
  output logic            out_can_take,
  output logic            result_valid,
  input  logic            result_stall,
  output logic [2:0]      kind,
  output logic [31:0]     address,
  output logic [7:0]      data
);

  assign out_can_take = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_can_take) begin
      result_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_can_take && res.valid) begin
      kind    <= res.kind;
      address <= res.address;
      data    <= res.data;
    end
  end

endmodule

// ===== tb/ihex_stream_checker.sv =====
// Checker for the Intel HEX record decoder: watches both channels, predicts words.
// Keeps its own parser state and compares every accepted output word in order.
// Depends on ihex_pkg for the kind, record type and character constants.
`timescale 1ns / 1ps

module ihex_stream_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  input  logic        char_stall,
  input  logic [7:0]  char_in,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [2:0]  kind,
  input  logic [31:0] address,
  input  logic [7:0]  data,
  output int          fails,
  output int          outstanding
);

  typedef enum logic [2:0] {
    SEEK_COLON, SKIP_LINE, GET_LEN, GET_OFS, GET_TYPE, GET_DATA, GET_SUM, SKIP_TAIL
  } parse_phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] address;
    logic [7:0]  data;
  } hex_word_t;

  hex_word_t    decoded_q[$];
  parse_phase_t phase = SEEK_COLON;
  logic         nib_pending = 1'b0;
  logic [3:0]   hi_nib = '0;
  logic [7:0]   idx = '0;
  logic [7:0]   rec_len = '0;
  logic [7:0]   rec_type = '0;
  logic [7:0]   sum = '0;
  logic [15:0]  rec_ofs = '0;
  logic [15:0]  ext_val = '0;
  logic [31:0]  base = '0;
  logic [31:0]  wr_addr = '0;
  logic         halted = 1'b0;
  int           fail_count = 0;
  int           queued = 0;

  assign fails = fail_count;
  assign outstanding = queued;

  // {is_hex, value}
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [7:0] folded;
    folded = c | 8'h20;
    if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
    if (folded >= "a" && folded <= "f") return {1'b1, folded[3:0] + 4'd9};
    return 5'd0;
  endfunction

  task automatic expect_word(input logic [2:0] k, input logic [31:0] a, input logic [7:0] d);
    hex_word_t w;
    w.kind = k;
    w.address = a;
    w.data = d;
    decoded_q.push_back(w);
  endtask

  task automatic decode_char(input logic [7:0] c);
    logic [4:0] dig;
    logic [7:0] b;
    if (halted) return;
    case (phase)
      SEEK_COLON: begin
        if (c == ihex_pkg::CHAR_COLON) begin
          phase = GET_LEN;
          nib_pending = 1'b0;
          hi_nib = '0;
          idx = '0;
          rec_len = '0;
          rec_ofs = '0;
          rec_type = '0;
          sum = '0;
        end else if (c != ihex_pkg::CHAR_LF) begin
          phase = SKIP_LINE;
        end
        return;
      end
      SKIP_LINE, SKIP_TAIL: begin
        if (c == ihex_pkg::CHAR_LF) phase = SEEK_COLON;
        return;
      end
      default: ;
    endcase
    dig = nibble_of(c);
    if (!dig[4]) begin
      halted = 1'b1;
      expect_word(ihex_pkg::KIND_FMTERR, '0, '0);
      return;
    end
    if (!nib_pending) begin
      hi_nib = dig[3:0];
      nib_pending = 1'b1;
      return;
    end
    nib_pending = 1'b0;
    b = {hi_nib, dig[3:0]};
    sum = sum + b;
    case (phase)
      GET_LEN: begin
        rec_len = b;
        idx = '0;
        phase = GET_OFS;
      end
      GET_OFS: begin
        rec_ofs = {rec_ofs[7:0], b};
        idx = idx + 8'd1;
        if (idx >= 8'd2) begin
          idx = '0;
          phase = GET_TYPE;
        end
      end
      GET_TYPE: begin
        rec_type = b;
        wr_addr = base + 32'(rec_ofs);
        ext_val = '0;
        idx = '0;
        phase = (rec_len != 8'd0) ? GET_DATA : GET_SUM;
      end
      GET_DATA: begin
        if (rec_type == ihex_pkg::REC_DATA) begin
          expect_word(ihex_pkg::KIND_WRITE, wr_addr, b);
          wr_addr = wr_addr + 32'd1;
        end else begin
          ext_val = {ext_val[7:0], b};
        end
        idx = idx + 8'd1;
        if (idx >= rec_len) phase = GET_SUM;
      end
      default: begin
        phase = SKIP_TAIL;
        if (sum != 8'd0) begin
          halted = 1'b1;
          expect_word(ihex_pkg::KIND_CKSERR, '0, '0);
        end else if (rec_type == ihex_pkg::REC_EOF) begin
          halted = 1'b1;
          expect_word(ihex_pkg::KIND_EOF, '0, '0);
        end else begin
          if (rec_type == ihex_pkg::REC_SEGMENT) base = 32'(ext_val) << 4;
          else if (rec_type == ihex_pkg::REC_LINEAR) base = 32'(ext_val) << 16;
          expect_word(ihex_pkg::KIND_GOOD, '0, '0);
        end
      end
    endcase
  endtask

  task automatic check_word();
    hex_word_t want;
    if (decoded_q.size() == 0) begin
      if (fail_count < 10)
        $display("unexpected word: kind %0d address %h data %h", kind, address, data);
      fail_count++;
      return;
    end
    want = decoded_q.pop_front();
    if (want.kind !== kind || want.address !== address || want.data !== data) begin
      if (fail_count < 10)
        $display("word mismatch: expected kind %0d address %h data %h, %s %0d %s %h %s %h",
                 want.kind, want.address, want.data, "got kind", kind, "address", address,
                 "data", data);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phase = SEEK_COLON;
      nib_pending = 1'b0;
      hi_nib = '0;
      idx = '0;
      rec_len = '0;
      rec_type = '0;
      sum = '0;
      rec_ofs = '0;
      ext_val = '0;
      base = '0;
      wr_addr = '0;
      halted = 1'b0;
      decoded_q.delete();
    end else begin
      // a word leaving now comes from a character that has passed the input and output registers
      if (result_valid && !result_stall) check_word();
      if (char_valid && !char_stall) decode_char(char_in);
    end
    queued <= decoded_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the Intel HEX decoder testbench: clock, reset, character stream, verdict.
// Builds directed and random hex text, drives it with random gaps and output stalls.
// Depends on ihex_pkg, intel_hex_record_decoder and ihex_stream_checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_CHARS = 900;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        char_valid = 1'b0;
  logic        char_stall;
  logic [7:0]  char_in = 8'h00;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [2:0]  kind;
  logic [31:0] address;
  logic [7:0]  data;
  int          fails;
  int          outstanding;
  int          cycles = 0;
  int          rx_cycle = 0;
  logic [7:0]  hex_text[$];
  logic [7:0]  rec_bytes[$];

  always #10 clk = ~clk;

  intel_hex_record_decoder i_dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_in      (char_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .address      (address),
    .data         (data)
  );

  ihex_stream_checker i_check (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_in      (char_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .address      (address),
    .data         (data),
    .fails        (fails),
    .outstanding  (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // output side: random stalls, one long hold-off, one stall-free stretch
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle >= 1500 && rx_cycle < 1900) result_stall <= 1'b1;
    else if (rx_cycle >= 2200 && rx_cycle < 2800) result_stall <= 1'b0;
    else result_stall <= ($urandom_range(99) < 38);
  end

  function automatic bit is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || ((c | 8'h20) >= "a" && (c | 8'h20) <= "f");
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (($urandom_range(1) != 0) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  task automatic add_byte(input logic [7:0] b);
    hex_text.push_back(hex_char(b[7:4]));
    hex_text.push_back(hex_char(b[3:0]));
  endtask

  task automatic add_line_end(input int tail_len);
    logic [7:0] c;
    for (int i = 0; i < tail_len; i++) begin
      c = ($urandom_range(4) == 0) ? ihex_pkg::CHAR_COLON : 8'($urandom_range(255));
      if (c == ihex_pkg::CHAR_LF) c = 8'hFF;
      hex_text.push_back(c);
    end
    hex_text.push_back(ihex_pkg::CHAR_LF);
  endtask

  task automatic add_noise_line();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == ihex_pkg::CHAR_COLON || c == ihex_pkg::CHAR_LF);
    hex_text.push_back(c);
    add_line_end($urandom_range(6));
  endtask

  task automatic fill_bytes(input int n);
    rec_bytes.delete();
    repeat (n) rec_bytes.push_back(8'($urandom_range(255)));
  endtask

  task automatic set_pair(input logic [15:0] v);
    rec_bytes.delete();
    rec_bytes.push_back(v[15:8]);
    rec_bytes.push_back(v[7:0]);
  endtask

  // sum_delta != 0 corrupts the checksum
  task automatic add_record(input logic [7:0] rtype, input logic [15:0] ofs,
                            input logic [7:0] sum_delta, input int tail_len);
    logic [7:0] sum;
    sum = 8'(rec_bytes.size()) + ofs[15:8] + ofs[7:0] + rtype;
    hex_text.push_back(ihex_pkg::CHAR_COLON);
    add_byte(8'(rec_bytes.size()));
    add_byte(ofs[15:8]);
    add_byte(ofs[7:0]);
    add_byte(rtype);
    foreach (rec_bytes[i]) begin
      add_byte(rec_bytes[i]);
      sum = sum + rec_bytes[i];
    end
    add_byte(sum_delta - sum);
    add_line_end(tail_len);
  endtask

  initial begin : stimulus
    int         start;
    int         pos;
    int         sel;
    logic [7:0] rtype;
    logic [7:0] bad;

    hex_text.push_back(ihex_pkg::CHAR_LF);
    add_noise_line();
    fill_bytes(1);
    rec_bytes[0] = 8'h00;
    add_record(ihex_pkg::REC_DATA, 16'h0000, 8'h00, 0);
    fill_bytes(4);
    foreach (rec_bytes[i]) rec_bytes[i] = 8'hFF;
    add_record(ihex_pkg::REC_DATA, 16'hFFFF, 8'h00, 6);
    fill_bytes(0);
    add_record(ihex_pkg::REC_DATA, 16'h1234, 8'h00, 0);
    set_pair(16'hFFFF);
    add_record(ihex_pkg::REC_LINEAR, 16'h0000, 8'h00, 0);
    fill_bytes(4);
    add_record(ihex_pkg::REC_DATA, 16'hFFFE, 8'h00, 0);
    set_pair(16'hFFFF);
    add_record(ihex_pkg::REC_SEGMENT, 16'h0000, 8'h00, 2);
    fill_bytes(3);
    add_record(ihex_pkg::REC_DATA, 16'hFFFF, 8'h00, 0);
    fill_bytes(0);
    add_record(ihex_pkg::REC_LINEAR, 16'h0000, 8'h00, 0);
    fill_bytes(3);
    add_record(ihex_pkg::REC_SEGMENT, 16'hABCD, 8'h00, 0);
    fill_bytes(2);
    add_record(ihex_pkg::REC_DATA, 16'($urandom), 8'h00, 0);
    fill_bytes(1);
    add_record(ihex_pkg::REC_LINEAR, 16'h0000, 8'h00, 0);
    fill_bytes(2);
    add_record(ihex_pkg::REC_DATA, 16'($urandom), 8'h00, 0);
    fill_bytes(4);
    add_record(8'h03, 16'h0000, 8'h00, 0);
    fill_bytes(0);
    add_record(8'h05, 16'h0000, 8'h00, 0);
    fill_bytes(2);
    add_record(8'hFF, 16'hFFFF, 8'h00, 0);
    fill_bytes(255);
    add_record(ihex_pkg::REC_DATA, 16'($urandom), 8'h00, 3);

    start = hex_text.size();
    while (hex_text.size() - start < RANDOM_CHARS) begin
      sel = $urandom_range(99);
      if (sel < 60) begin
        fill_bytes(($urandom_range(99) < 3) ? $urandom_range(255) : $urandom_range(24));
        add_record(ihex_pkg::REC_DATA, 16'($urandom), 8'h00,
                   ($urandom_range(3) == 0) ? 3 : 0);
      end else if (sel < 75) begin
        fill_bytes(($urandom_range(99) < 80) ? 2 : $urandom_range(4));
        add_record(($urandom_range(1) != 0) ? ihex_pkg::REC_LINEAR : ihex_pkg::REC_SEGMENT,
                   16'($urandom), 8'h00, ($urandom_range(3) == 0) ? 2 : 0);
      end else if (sel < 80) begin
        do rtype = 8'($urandom_range(255));
        while (rtype == ihex_pkg::REC_DATA || rtype == ihex_pkg::REC_EOF ||
               rtype == ihex_pkg::REC_SEGMENT || rtype == ihex_pkg::REC_LINEAR);
        fill_bytes($urandom_range(6));
        add_record(rtype, 16'($urandom), 8'h00, 0);
      end else if (sel < 90) begin
        add_noise_line();
      end else begin
        hex_text.push_back(ihex_pkg::CHAR_LF);
      end
    end

    // one halting record closes the decoded part of the stream
    case ($urandom_range(2))
      0: begin
        fill_bytes($urandom_range(3));
        add_record(ihex_pkg::REC_EOF, 16'($urandom), 8'h00, 0);
      end
      1: begin
        fill_bytes($urandom_range(8));
        add_record(ihex_pkg::REC_DATA, 16'($urandom), 8'($urandom_range(1, 255)), 0);
      end
      default: begin
        start = hex_text.size();
        fill_bytes($urandom_range(6));
        add_record(ihex_pkg::REC_DATA, 16'($urandom), 8'h00, 0);
        pos = start + $urandom_range(1, 2 * (rec_bytes.size() + 5));
        case ($urandom_range(2))
          0: bad = ihex_pkg::CHAR_LF;
          1: bad = ihex_pkg::CHAR_COLON;
          default: begin
            do bad = 8'($urandom_range(255)); while (is_hex(bad));
          end
        endcase
        hex_text[pos] = bad;
      end
    endcase
    fill_bytes(2);
    add_record(ihex_pkg::REC_DATA, 16'($urandom), 8'h00, 0);
    add_noise_line();

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (hex_text[i]) begin
      while (!(i >= 900 && i < 1300) && $urandom_range(99) < 38) begin
        char_valid <= 1'b0;
        @(posedge clk);
      end
      char_valid <= 1'b1;
      char_in <= hex_text[i];
      do @(posedge clk); while (char_stall);
    end
    char_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fails == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ihex_pkg.sv
rtl/ihex_in_reg.sv
rtl/ihex_core.sv
rtl/ihex_out_reg.sv
rtl/intel_hex_record_decoder.sv
tb/ihex_stream_checker.sv
tb/tb_top.sv
